@@ hdl/svn_pkg.sv @@
// shared types, constants and codes for the smooth vertex normal accumulator
`timescale 1ns / 1ps
package svn_pkg;

  localparam int unsigned MAX_VERTICES = 1024;
  localparam int unsigned ADDR_W = $clog2(MAX_VERTICES);
  localparam int unsigned IDX_W = 10;
  localparam int unsigned POS_W = 32;
  localparam int unsigned SUM_W = 24;
  localparam int unsigned NRM_W = 16;

  typedef logic [ADDR_W-1:0] addr_t;

  typedef enum logic [1:0] {
    CMD_STORE = 2'd0,
    CMD_TRI   = 2'd1,
    CMD_READ  = 2'd2,
    CMD_CLEAR = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ALU_ADD,
    ALU_SUB,
    ALU_MUL
  } alu_op_t;

  typedef enum logic [4:0] {
    S_CLR, S_IDLE, S_TA, S_TB, S_E1, S_TC, S_E2, S_SCL,
    S_XM1, S_XM2, S_XS, S_RS, S_RW, S_ABS, S_ZCHK, S_NORM,
    S_SQM, S_SQA, S_SQRT, S_DIVN, S_DIV, S_SGN, S_ACC, S_ACCW, S_OUT
  } state_t;

  typedef struct packed {
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
    logic signed [POS_W-1:0] z;
  } pos_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] x;
    logic signed [SUM_W-1:0] y;
    logic signed [SUM_W-1:0] z;
  } sumv_t;

  typedef struct packed {
    alu_op_t     op;
    logic [63:0] a;
    logic [63:0] b;
  } alu_req_t;

  typedef struct packed {
    logic  vwe;
    logic  vre;
    addr_t vaddr;
    pos_t  vwdata;
    logic  swe;
    logic  sre;
    addr_t saddr;
    sumv_t swdata;
  } mem_req_t;

  typedef struct packed {
    pos_t  vrdata;
    sumv_t srdata;
  } mem_rsp_t;

endpackage

@@ hdl/svn_in_if.sv @@
// command word channel
`timescale 1ns / 1ps
interface svn_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [9:0]  index_a;
  logic [9:0]  index_b;
  logic [9:0]  index_c;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;

  modport source (output valid, command, index_a, index_b, index_c, pos_x, pos_y, pos_z,
                  input ready);
  modport sink (input valid, command, index_a, index_b, index_c, pos_x, pos_y, pos_z,
                output ready);
endinterface

@@ hdl/svn_out_if.sv @@
// normal result word channel
`timescale 1ns / 1ps
interface svn_out_if;
  logic        valid;
  logic        ready;
  logic signed [15:0] normal_x;
  logic signed [15:0] normal_y;
  logic signed [15:0] normal_z;
  logic        sum_is_zero;

  modport source (output valid, normal_x, normal_y, normal_z, sum_is_zero, input ready);
  modport sink (input valid, normal_x, normal_y, normal_z, sum_is_zero, output ready);
endinterface

@@ hdl/svn_mem.sv @@
// position and normal sum memories with registered reads
`timescale 1ns / 1ps
module svn_mem import svn_pkg::*; (
  input  logic     clk,
  input  mem_req_t req,
  output mem_rsp_t rsp
);

  logic signed [POS_W-1:0] vx [MAX_VERTICES];
  logic signed [POS_W-1:0] vy [MAX_VERTICES];
  logic signed [POS_W-1:0] vz [MAX_VERTICES];
  logic signed [SUM_W-1:0] sx [MAX_VERTICES];
  logic signed [SUM_W-1:0] sy [MAX_VERTICES];
  logic signed [SUM_W-1:0] sz [MAX_VERTICES];

  // vertex positions and normal sums
  always_ff @(posedge clk) begin
    if (req.vwe) begin
      vx[req.vaddr] <= req.vwdata.x;
      vy[req.vaddr] <= req.vwdata.y;
      vz[req.vaddr] <= req.vwdata.z;
    end
    if (req.vre) begin
      rsp.vrdata.x <= vx[req.vaddr];
      rsp.vrdata.y <= vy[req.vaddr];
      rsp.vrdata.z <= vz[req.vaddr];
    end
    if (req.swe) begin
      sx[req.saddr] <= req.swdata.x;
      sy[req.saddr] <= req.swdata.y;
      sz[req.saddr] <= req.swdata.z;
    end
    if (req.sre) begin
      rsp.srdata.x <= sx[req.saddr];
      rsp.srdata.y <= sy[req.saddr];
      rsp.srdata.z <= sz[req.saddr];
    end
  end

endmodule

@@ hdl/svn_alu.sv @@
// shared add, subtract and multiply unit
`timescale 1ns / 1ps
module svn_alu import svn_pkg::*; (
  input  alu_req_t    req,
  output logic [63:0] y
);

  logic signed [63:0] ma;
  logic signed [63:0] mb;

  // sign-extended multiplier operands
  assign ma = {{32{req.a[31]}}, req.a[31:0]};
  assign mb = {{32{req.b[31]}}, req.b[31:0]};

  always_comb begin
    unique case (req.op)
      ALU_ADD: y = req.a + req.b;
      ALU_SUB: y = req.a - req.b;
      ALU_MUL: y = ma * mb;
      default: y = '0;
    endcase
  end

endmodule

@@ hdl/svn_ctrl.sv @@
// sequencer and working registers for triangle normals and vertex reads
`timescale 1ns / 1ps
module svn_ctrl import svn_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  svn_in_if.sink      request,
  svn_out_if.source   response,
  output alu_req_t    alu_req,
  input  logic [63:0] alu_y,
  output mem_req_t    mem_req,
  input  mem_rsp_t    mem_rsp
);

  state_t state, state_next;
  cmd_t   cmd;
  logic [IDX_W-1:0] idx [3];
  logic [1:0]  k;
  logic [4:0]  cnt;
  addr_t       clr_addr;
  pos_t        pa;
  logic        e1s [3];
  logic        e2s [3];
  logic [32:0] e1m [3];
  logic [32:0] e2m [3];
  logic [63:0] tmp_a, tmp_b, acc;
  logic [63:0] v [3];
  logic        sgn [3];
  logic [61:0] m [3];
  logic [63:0] sq_x;
  logic [33:0] sq_rem;
  logic [31:0] sq_q;
  logic [45:0] num, dvs;
  logic [15:0] quo;
  logic signed [16:0] n [3];
  logic        zflag;
  logic        out_valid;
  logic signed [15:0] out_x, out_y, out_z;
  logic        out_zero;

  logic        accept, out_load;
  logic        rng_a, rng_all;
  logic [31:0] e1v [3];
  logic [31:0] e2v [3];
  logic [31:0] xa, xb, xc, xd;
  logic        big, all_zero;
  logic [61:0] m_or;
  logic [35:0] remt;
  logic [33:0] trial;
  logic [IDX_W-1:0] cur_idx;
  logic signed [SUM_W-1:0] sat [3];
  logic signed [SUM_W-1:0] cur_sum [3];

  function automatic logic [31:0] edge_val(input logic s, input logic [32:0] mg);
    logic [31:0] t;
    t = {2'b00, mg[29:0]};
    return s ? (~t + 32'd1) : t;
  endfunction

  function automatic logic [63:0] pos_comp(input pos_t p, input logic [1:0] c);
    logic [31:0] r;
    r = (c == 2'd0) ? p.x : ((c == 2'd1) ? p.y : p.z);
    return {{32{r[31]}}, r};
  endfunction

  function automatic logic signed [SUM_W-1:0] sat_add(input logic signed [SUM_W-1:0] s,
                                                       input logic signed [16:0] d);
    logic signed [SUM_W:0] t;
    t = {s[SUM_W-1], s} + {{(SUM_W-16){d[16]}}, d};
    if (t[SUM_W] != t[SUM_W-1])
      return t[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
    return t[SUM_W-1:0];
  endfunction

  // handshakes and range checks
  assign accept   = request.valid && request.ready;
  assign out_load = !out_valid || response.ready;
  assign rng_a    = 32'(request.index_a) < MAX_VERTICES;
  assign rng_all  = rng_a && (32'(request.index_b) < MAX_VERTICES)
                    && (32'(request.index_c) < MAX_VERTICES);

  // signed edge values and cross product operands
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      e1v[i] = edge_val(e1s[i], e1m[i]);
      e2v[i] = edge_val(e2s[i], e2m[i]);
    end
    case (k)
      2'd0:    begin xa = e1v[1]; xb = e2v[2]; xc = e1v[2]; xd = e2v[1]; end
      2'd1:    begin xa = e1v[2]; xb = e2v[0]; xc = e1v[0]; xd = e2v[2]; end
      default: begin xa = e1v[0]; xb = e2v[1]; xc = e1v[1]; xd = e2v[0]; end
    endcase
  end

  // misc status
  assign big      = (e1m[0][32:30] | e1m[1][32:30] | e1m[2][32:30]
                    | e2m[0][32:30] | e2m[1][32:30] | e2m[2][32:30]) != 3'd0;
  assign m_or     = m[0] | m[1] | m[2];
  assign all_zero = m_or == '0;
  assign remt     = {sq_rem, sq_x[63:62]};
  assign trial    = {sq_q, 2'b01};
  assign cur_idx  = idx[k];
  assign cur_sum[0] = mem_rsp.srdata.x;
  assign cur_sum[1] = mem_rsp.srdata.y;
  assign cur_sum[2] = mem_rsp.srdata.z;
  always_comb begin
    for (int i = 0; i < 3; i++) sat[i] = sat_add(cur_sum[i], n[i]);
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_CLR:  if (clr_addr == ADDR_W'(MAX_VERTICES - 1)) state_next = S_IDLE;
      S_IDLE: begin
        if (accept) begin
          unique case (cmd_t'(request.command))
            CMD_STORE: state_next = S_IDLE;
            CMD_TRI:   state_next = rng_all ? S_TA : S_IDLE;
            CMD_READ:  state_next = rng_a ? S_RS : S_OUT;
            CMD_CLEAR: state_next = S_CLR;
          endcase
        end
      end
      S_TA:   state_next = S_TB;
      S_TB:   state_next = S_E1;
      S_E1:   if (k == 2'd2) state_next = S_TC;
      S_TC:   state_next = S_E2;
      S_E2:   if (k == 2'd2) state_next = S_SCL;
      S_SCL:  if (!big) state_next = S_XM1;
      S_XM1:  state_next = S_XM2;
      S_XM2:  state_next = S_XS;
      S_XS:   state_next = (k == 2'd2) ? S_ABS : S_XM1;
      S_RS:   state_next = S_RW;
      S_RW:   state_next = S_ABS;
      S_ABS:  if (k == 2'd2) state_next = S_ZCHK;
      S_ZCHK: begin
        if (!all_zero) state_next = S_NORM;
        else state_next = (cmd == CMD_TRI) ? S_IDLE : S_OUT;
      end
      S_NORM: if (m_or[61:30] == '0 && m_or[29]) state_next = S_SQM;
      S_SQM:  state_next = S_SQA;
      S_SQA:  state_next = (k == 2'd2) ? S_SQRT : S_SQM;
      S_SQRT: if (cnt == 5'd31) state_next = S_DIVN;
      S_DIVN: state_next = S_DIV;
      S_DIV:  if (cnt == 5'd15) state_next = S_SGN;
      S_SGN: begin
        if (k != 2'd2) state_next = S_DIVN;
        else state_next = (cmd == CMD_TRI) ? S_ACC : S_OUT;
      end
      S_ACC:  state_next = S_ACCW;
      S_ACCW: state_next = (k == 2'd2) ? S_IDLE : S_ACC;
      S_OUT:  if (out_load) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // memory and unit controls
  always_comb begin
    request.ready = state == S_IDLE;
    mem_req = '0;
    alu_req = '{op: ALU_ADD, a: '0, b: '0};
    unique case (state)
      S_CLR: begin
        mem_req.swe   = 1'b1;
        mem_req.saddr = clr_addr;
      end
      S_IDLE: begin
        mem_req.vwe    = accept && cmd_t'(request.command) == CMD_STORE && rng_a;
        mem_req.vaddr  = ADDR_W'(request.index_a);
        mem_req.vwdata = '{x: request.pos_x, y: request.pos_y, z: request.pos_z};
      end
      S_TA: begin mem_req.vre = 1'b1; mem_req.vaddr = ADDR_W'(idx[0]); end
      S_TB: begin mem_req.vre = 1'b1; mem_req.vaddr = ADDR_W'(idx[1]); end
      S_TC: begin mem_req.vre = 1'b1; mem_req.vaddr = ADDR_W'(idx[2]); end
      S_E1, S_E2: alu_req = '{op: ALU_SUB, a: pos_comp(mem_rsp.vrdata, k),
                              b: pos_comp(pa, k)};
      S_XM1:  alu_req = '{op: ALU_MUL, a: 64'(xa), b: 64'(xb)};
      S_XM2:  alu_req = '{op: ALU_MUL, a: 64'(xc), b: 64'(xd)};
      S_XS:   alu_req = '{op: ALU_SUB, a: tmp_a, b: tmp_b};
      S_RS: begin mem_req.sre = 1'b1; mem_req.saddr = ADDR_W'(idx[0]); end
      S_ABS:  alu_req = '{op: ALU_SUB, a: '0, b: v[k]};
      S_SQM:  alu_req = '{op: ALU_MUL, a: 64'(m[k]), b: 64'(m[k])};
      S_SQA:  alu_req = '{op: ALU_ADD, a: acc, b: tmp_a};
      S_SQRT: alu_req = '{op: ALU_SUB, a: 64'(remt), b: 64'(trial)};
      S_DIVN: alu_req = '{op: ALU_ADD, a: 64'({m[k][29:0], 15'd0}), b: 64'(sq_q[31:1])};
      S_DIV:  alu_req = '{op: ALU_SUB, a: 64'(num), b: 64'(dvs)};
      S_ACC: begin mem_req.sre = 1'b1; mem_req.saddr = ADDR_W'(cur_idx); end
      S_ACCW: begin
        mem_req.swe    = 1'b1;
        mem_req.saddr  = ADDR_W'(cur_idx);
        mem_req.swdata = '{x: sat[0], y: sat[1], z: sat[2]};
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLR;
      clr_addr  <= '0;
      k         <= '0;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_CLR) clr_addr <= clr_addr + 1'b1;
      else clr_addr <= '0;
      if (((state == S_E1 || state == S_E2 || state == S_ABS || state == S_SQA
            || state == S_SGN || state == S_ACCW)) || (state == S_XS))
        k <= (k == 2'd2) ? 2'd0 : k + 2'd1;
      if (state == S_SQRT || state == S_DIV) cnt <= (state_next == state) ? cnt + 5'd1 : 5'd0;
      else cnt <= '0;
      if (state == S_OUT && out_load) out_valid <= 1'b1;
      else if (response.ready) out_valid <= 1'b0;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          cmd    <= cmd_t'(request.command);
          idx[0] <= request.index_a;
          idx[1] <= request.index_b;
          idx[2] <= request.index_c;
          zflag  <= 1'b1;
          for (int i = 0; i < 3; i++) n[i] <= '0;
        end
      end
      S_TB: pa <= mem_rsp.vrdata;
      S_E1: begin
        e1s[k] <= alu_y[63];
        e1m[k] <= alu_y[63] ? (~alu_y[32:0] + 33'd1) : alu_y[32:0];
      end
      S_E2: begin
        e2s[k] <= alu_y[63];
        e2m[k] <= alu_y[63] ? (~alu_y[32:0] + 33'd1) : alu_y[32:0];
      end
      S_SCL: begin
        if (big) begin
          for (int i = 0; i < 3; i++) begin
            e1m[i] <= e1m[i] >> 1;
            e2m[i] <= e2m[i] >> 1;
          end
        end
      end
      S_XM1: tmp_a <= alu_y;
      S_XM2: tmp_b <= alu_y;
      S_XS:  v[k] <= alu_y;
      S_RW: begin
        v[0] <= 64'(mem_rsp.srdata.x);
        v[1] <= 64'(mem_rsp.srdata.y);
        v[2] <= 64'(mem_rsp.srdata.z);
      end
      S_ABS: begin
        sgn[k] <= v[k][63];
        m[k]   <= v[k][63] ? alu_y[61:0] : v[k][61:0];
      end
      S_ZCHK: begin
        acc   <= '0;
        zflag <= all_zero;
      end
      // bring the largest magnitude into [2^29, 2^30)
      S_NORM: begin
        for (int i = 0; i < 3; i++) begin
          if (m_or[61:38] != '0) m[i] <= m[i] >> 8;
          else if (m_or[37:30] != '0) m[i] <= m[i] >> 1;
          else if (m_or[29:21] == '0) m[i] <= m[i] << 8;
          else if (!m_or[29]) m[i] <= m[i] << 1;
        end
      end
      S_SQM: tmp_a <= alu_y;
      S_SQA: begin
        acc    <= alu_y;
        sq_x   <= alu_y;
        sq_rem <= '0;
        sq_q   <= '0;
      end
      // one root bit a step
      S_SQRT: begin
        if (!alu_y[63]) begin
          sq_rem <= alu_y[33:0];
          sq_q   <= {sq_q[30:0], 1'b1};
        end else begin
          sq_rem <= remt[33:0];
          sq_q   <= {sq_q[30:0], 1'b0};
        end
        sq_x <= {sq_x[61:0], 2'b00};
      end
      S_DIVN: begin
        num <= alu_y[45:0];
        dvs <= {sq_q[30:0], 15'd0};
        quo <= '0;
      end
      // one quotient bit a step
      S_DIV: begin
        if (!alu_y[63]) num <= alu_y[45:0];
        quo <= {quo[14:0], !alu_y[63]};
        dvs <= dvs >> 1;
      end
      S_SGN: n[k] <= sgn[k] ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
      S_OUT: begin
        if (out_load) begin
          out_x    <= (n[0] == 17'sd32768) ? 16'sd32767 : n[0][15:0];
          out_y    <= (n[1] == 17'sd32768) ? 16'sd32767 : n[1][15:0];
          out_z    <= (n[2] == 17'sd32768) ? 16'sd32767 : n[2][15:0];
          out_zero <= zflag;
        end
      end
      default: ;
    endcase
  end

  // result word
  assign response.valid       = out_valid;
  assign response.normal_x    = out_x;
  assign response.normal_y    = out_y;
  assign response.normal_z    = out_z;
  assign response.sum_is_zero = out_zero;

endmodule

@@ hdl/smooth_vertex_normal_accumulator_unit.sv @@
// top level of the smooth vertex normal accumulator
// store: the unit stays idle, so the next word is taken in the following cycle
// read: the result word is set by the 32-step square root and three 16-step divides
//   on the shared add/multiply unit; a triangle runs them too, before accumulating
// clear, and reset: each of the 1024 sums is zeroed in turn, no word is taken meanwhile
// one word in flight at a time; the result register lets the next word in while it waits
`timescale 1ns / 1ps
module smooth_vertex_normal_accumulator_unit import svn_pkg::*; (
  input logic       clk,
  input logic       rst,
  svn_in_if.sink    request,
  svn_out_if.source response
);

  alu_req_t    alu_req;
  logic [63:0] alu_y;
  mem_req_t    mem_req;
  mem_rsp_t    mem_rsp;

  // sequencer
  svn_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .request  (request),
    .response (response),
    .alu_req  (alu_req),
    .alu_y    (alu_y),
    .mem_req  (mem_req),
    .mem_rsp  (mem_rsp)
  );

  // shared arithmetic
  svn_alu u_alu (
    .req (alu_req),
    .y   (alu_y)
  );

  // storage
  svn_mem u_mem (
    .clk (clk),
    .req (mem_req),
    .rsp (mem_rsp)
  );

endmodule

@@ hdl/svn_chk.sv @@
// port checker for the smooth vertex normal accumulator
`timescale 1ns / 1ps
module svn_chk import svn_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic [1:0]  in_command,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] out_x,
  input logic [15:0] out_y,
  input logic [15:0] out_z,
  input logic        out_zero
);

  // a waiting result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable({out_x, out_y, out_z, out_zero}))
    else $error("result word changed while stalled");

  // zero flag comes with a zero normal
  a_zero_norm: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_zero |-> out_x == '0 && out_y == '0 && out_z == '0)
    else $error("zero flag with non-zero normal");

  // a unit normal is never all zero
  a_unit_norm: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_zero |-> out_x != '0 || out_y != '0 || out_z != '0)
    else $error("unit normal reads as zero");

  // work beyond a store holds the input off
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && cmd_t'(in_command) != CMD_STORE |=> !in_ready)
    else $error("input taken while busy");

  // reset starts the clearing pass
  a_rst_clear: assert property (@(posedge clk) rst |=> !in_ready)
    else $error("ready during clearing pass");

endmodule

bind smooth_vertex_normal_accumulator_unit svn_chk u_svn_chk (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (request.valid),
  .in_ready   (request.ready),
  .in_command (request.command),
  .out_valid  (response.valid),
  .out_ready  (response.ready),
  .out_x      (response.normal_x),
  .out_y      (response.normal_y),
  .out_z      (response.normal_z),
  .out_zero   (response.sum_is_zero)
);

@@ tb/sv/svn_normal_checker.sv @@
// checker: watches both channels, predicts vertex normals and compares
`timescale 1ns / 1ps
module svn_normal_checker import svn_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  svn_in_if.sink    request,
  svn_out_if.sink   response,
  output int        fail_count,
  output int        pending
);

  typedef struct packed {
    logic signed [15:0] nx;
    logic signed [15:0] ny;
    logic signed [15:0] nz;
    logic               zero;
  } normal_word_t;

  logic signed [31:0] vx [MAX_VERTICES];
  logic signed [31:0] vy [MAX_VERTICES];
  logic signed [31:0] vz [MAX_VERTICES];
  logic signed [31:0] sx [MAX_VERTICES];
  logic signed [31:0] sy [MAX_VERTICES];
  logic signed [31:0] sz [MAX_VERTICES];
  normal_word_t expected_normals[$];

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint unsigned magnitude(longint v);
    return v < 0 ? longint'(-v) : longint'(v);
  endfunction

  // scale to unit length in q.15, returns 0 for a zero vector
  function automatic bit make_unit(input longint v[3], output int u[3]);
    longint unsigned m[3], top, sq, len, q;
    for (int i = 0; i < 3; i++) begin
      m[i] = magnitude(v[i]);
      u[i] = 0;
    end
    top = m[0];
    if (m[1] > top) top = m[1];
    if (m[2] > top) top = m[2];
    if (top == 0) return 0;
    while (top < (64'd1 << 29)) begin
      top = top << 1;
      for (int i = 0; i < 3; i++) m[i] = m[i] << 1;
    end
    while (top >= (64'd1 << 30)) begin
      top = top >> 1;
      for (int i = 0; i < 3; i++) m[i] = m[i] >> 1;
    end
    sq = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
    len = int_sqrt(sq);
    for (int i = 0; i < 3; i++) begin
      q = (m[i] * 32768 + len / 2) / len;
      u[i] = v[i] < 0 ? -int'(q) : int'(q);
    end
    return 1;
  endfunction

  function automatic int sat_sum(int s, int d);
    longint t;
    t = longint'(s) + d;
    if (t > 8388607) return 8388607;
    if (t < -8388608) return -8388608;
    return int'(t);
  endfunction

  function automatic longint halve_mag(longint v);
    return v < 0 ? -longint'(magnitude(v) >> 1) : v >>> 1;
  endfunction

  // face normal into the three corner sums
  task automatic add_face(int a, int b, int c);
    longint e1[3], e2[3], cr[3];
    longint unsigned top;
    int n[3];
    int idx[3];
    e1[0] = longint'(vx[b]) - vx[a];
    e1[1] = longint'(vy[b]) - vy[a];
    e1[2] = longint'(vz[b]) - vz[a];
    e2[0] = longint'(vx[c]) - vx[a];
    e2[1] = longint'(vy[c]) - vy[a];
    e2[2] = longint'(vz[c]) - vz[a];
    top = 0;
    for (int i = 0; i < 3; i++) begin
      if (magnitude(e1[i]) > top) top = magnitude(e1[i]);
      if (magnitude(e2[i]) > top) top = magnitude(e2[i]);
    end
    while (top >= (64'd1 << 30)) begin
      top = top >> 1;
      for (int i = 0; i < 3; i++) begin
        e1[i] = halve_mag(e1[i]);
        e2[i] = halve_mag(e2[i]);
      end
    end
    cr[0] = e1[1] * e2[2] - e1[2] * e2[1];
    cr[1] = e1[2] * e2[0] - e1[0] * e2[2];
    cr[2] = e1[0] * e2[1] - e1[1] * e2[0];
    if (!make_unit(cr, n)) return;
    idx[0] = a;
    idx[1] = b;
    idx[2] = c;
    for (int k = 0; k < 3; k++) begin
      sx[idx[k]] = sat_sum(sx[idx[k]], n[0]);
      sy[idx[k]] = sat_sum(sy[idx[k]], n[1]);
      sz[idx[k]] = sat_sum(sz[idx[k]], n[2]);
    end
  endtask

  function automatic normal_word_t read_normal(int a);
    normal_word_t w;
    longint s[3];
    int u[3];
    bit nz;
    s[0] = sx[a];
    s[1] = sy[a];
    s[2] = sz[a];
    nz = make_unit(s, u);
    for (int i = 0; i < 3; i++) if (u[i] > 32767) u[i] = 32767;
    w.nx = u[0][15:0];
    w.ny = u[1][15:0];
    w.nz = u[2][15:0];
    w.zero = !nz;
    return w;
  endfunction

  assign pending = expected_normals.size();

  // predict on each accepted command word
  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_VERTICES; i++) begin
        vx[i] = 0; vy[i] = 0; vz[i] = 0;
        sx[i] = 0; sy[i] = 0; sz[i] = 0;
      end
    end else if (request.valid && request.ready) begin
      case (cmd_t'(request.command))
        CMD_STORE: begin
          vx[request.index_a] = request.pos_x;
          vy[request.index_a] = request.pos_y;
          vz[request.index_a] = request.pos_z;
        end
        CMD_TRI: add_face(request.index_a, request.index_b, request.index_c);
        CMD_READ: expected_normals.push_back(read_normal(request.index_a));
        CMD_CLEAR: begin
          for (int i = 0; i < MAX_VERTICES; i++) begin
            sx[i] = 0; sy[i] = 0; sz[i] = 0;
          end
        end
      endcase
    end
  end

  // compare each accepted result word
  initial fail_count = 0;
  always @(posedge clk) begin
    normal_word_t exp_w, got;
    if (!rst && response.valid && response.ready) begin
      got = {response.normal_x, response.normal_y, response.normal_z, response.sum_is_zero};
      if (expected_normals.size() == 0) begin
        $display("%0t: unexpected result word %h", $time, got);
        fail_count++;
      end else begin
        exp_w = expected_normals.pop_front();
        if (got !== exp_w) begin
          $display("%0t: normal mismatch expected x=%0d y=%0d z=%0d zero=%0b actual x=%0d y=%0d z=%0d zero=%0b",
                   $time, exp_w.nx, exp_w.ny, exp_w.nz, exp_w.zero,
                   got.nx, got.ny, got.nz, got.zero);
          fail_count++;
        end
      end
    end
  end

endmodule

@@ tb/sv/tb_smooth_vertex_normal_accumulator_unit.sv @@
// testbench top: stimulus for the vertex normal accumulator and final verdict
`timescale 1ns / 1ps
module tb_smooth_vertex_normal_accumulator_unit;
  import svn_pkg::*;

  logic clk = 0;
  logic rst = 1;
  int   fail_count;
  int   pending;
  bit   quiet = 0;
  bit   hold_off = 0;
  int   written[$];

  svn_in_if  request();
  svn_out_if response();

  smooth_vertex_normal_accumulator_unit dut (
    .clk(clk), .rst(rst), .request(request.sink), .response(response.source)
  );

  svn_normal_checker checker_i (
    .clk(clk), .rst(rst), .request(request.sink), .response(response.sink),
    .fail_count(fail_count), .pending(pending)
  );

  always #2 clk = ~clk;

  // receiver with random stall bursts and an optional long hold-off
  initial response.ready = 0;
  always @(posedge clk) begin
    int burst;
    if (hold_off) begin
      response.ready <= 0;
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      burst = $urandom_range(1, 3);
      response.ready <= 0;
      repeat (burst - 1) @(posedge clk);
    end else begin
      response.ready <= 1;
    end
  end

  task automatic send_word(cmd_t c, int a, int b, int d, int px, int py, int pz);
    int gap;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 3);
      request.valid <= 0;
      repeat (gap) @(posedge clk);
    end
    request.valid   <= 1;
    request.command <= c;
    request.index_a <= a[9:0];
    request.index_b <= b[9:0];
    request.index_c <= d[9:0];
    request.pos_x   <= px;
    request.pos_y   <= py;
    request.pos_z   <= pz;
    @(posedge clk);
    while (!request.ready) @(posedge clk);
    if (c == CMD_STORE) written.push_back(a);
  endtask

  task automatic go_idle();
    request.valid <= 0;
    @(posedge clk);
  endtask

  function automatic int pick_written();
    return written[$urandom_range(0, written.size() - 1)];
  endfunction

  function automatic int rand_pos();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
      default: return int'($urandom_range(0, 2000000)) - 1000000;
    endcase
  endfunction

  task automatic store_random(int a);
    send_word(CMD_STORE, a, $urandom_range(0, 1023), $urandom_range(0, 1023),
              rand_pos(), rand_pos(), rand_pos());
  endtask

  initial begin
    int a, b, c;
    request.valid = 0; request.command = 0; request.index_a = 0; request.index_b = 0;
    request.index_c = 0; request.pos_x = 0; request.pos_y = 0; request.pos_z = 0;
    repeat (8) @(posedge clk);
    rst <= 0;

    // directed: extremes, degenerate face, saturation, clear
    send_word(CMD_READ, 5, 0, 0, 0, 0, 0);
    send_word(CMD_STORE, 0, 1023, 1023, 0, 0, 0);
    send_word(CMD_STORE, 1, 0, 0, 32'h00010000, 0, 0);
    send_word(CMD_STORE, 2, 0, 0, 0, 32'h00010000, 0);
    send_word(CMD_STORE, 1023, 0, 0, 32'h7fffffff, 32'h80000000, 32'h7fffffff);
    send_word(CMD_STORE, 1022, 0, 0, 32'h80000000, 32'h7fffffff, 32'hffffffff);
    send_word(CMD_TRI, 0, 1, 2, 0, 0, 0);
    send_word(CMD_READ, 0, 0, 0, 0, 0, 0);
    send_word(CMD_TRI, 0, 0, 1, 0, 0, 0);
    send_word(CMD_TRI, 0, 1023, 1022, 0, 0, 0);
    send_word(CMD_READ, 1023, 0, 0, 0, 0, 0);
    for (int i = 0; i < 10; i++) send_word(CMD_TRI, 1, 2, 0, 0, 0, 0);
    send_word(CMD_READ, 2, 0, 0, 0, 0, 0);
    send_word(CMD_CLEAR, 0, 0, 0, 0, 0, 0);
    send_word(CMD_READ, 0, 0, 0, 0, 0, 0);

    // saturation: 300 identical faces into corner 0
    quiet = 1;
    for (int i = 0; i < 300; i++) send_word(CMD_TRI, 0, 1, 2, 0, 0, 0);
    send_word(CMD_READ, 0, 0, 0, 0, 0, 0);
    quiet = 0;

    // long receiver hold-off while reads keep coming
    hold_off = 1;
    fork
      begin
        int n;
        n = 0;
        while (n < 400) begin
          @(posedge clk);
          n++;
        end
        hold_off = 0;
      end
      for (int i = 0; i < 6; i++) send_word(CMD_READ, i % 3, 0, 0, 0, 0, 0);
    join

    // pause until every result has arrived
    go_idle();
    while (pending != 0) @(posedge clk);

    // random part: small meshes, reads, occasional clears
    for (int i = 0; i < 1620; i++) begin
      if (i > 1460) quiet = 1;
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4: store_random($urandom_range(0, 1023));
        5, 6, 7, 8, 9, 10, 11: begin
          a = pick_written(); b = pick_written(); c = pick_written();
          send_word(CMD_TRI, a, b, c, $urandom(), $urandom(), $urandom());
        end
        12, 13, 14, 15, 16, 17: begin
          a = $urandom_range(0, 9) == 0 ? $urandom_range(0, 1023) : pick_written();
          send_word(CMD_READ, a, $urandom_range(0, 1023), $urandom_range(0, 1023),
                    $urandom(), $urandom(), $urandom());
        end
        18: store_random(pick_written());
        default: if ($urandom_range(0, 3) == 0)
          send_word(CMD_CLEAR, $urandom_range(0, 1023), 0, 0, 0, 0, 0);
      endcase
    end
    go_idle();
    while (pending != 0) @(posedge clk);
    repeat (1200) @(posedge clk);
    if (fail_count == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

  // run limit
  initial begin
    #(4 * 1500000);
    $display("== FAIL ==");
    $finish;
  end

endmodule
